FILE: design/doubly_linked_list_engine_macros.svh
// assertion macros for the doubly linked list engine
// no dependencies; included by files that carry concurrent checks
`ifndef DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DLLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DLLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dlle_pkg.sv
// shared types and constants of the doubly linked list engine
// no dependencies; used by the interfaces and the top level
package dlle_pkg;

    localparam int ACTION_W = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT    = 3'd0,
        ACT_DEL_KEY   = 3'd1,
        ACT_DEL_FIRST = 3'd2,
        ACT_DEL_LAST  = 3'd3,
        ACT_DUMP      = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC,
        ST_LINK,
        ST_FIX,
        ST_WALK,
        ST_UNLINK,
        ST_RESP
    } t_state;

endpackage

FILE: design/dlle_cmd_if.sv
// command channel: valid/ready handshake with action and key
// depends on dlle_pkg
interface dlle_cmd_if
    import dlle_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic signed [KEY_W-1:0]  key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

FILE: design/dlle_rsp_if.sv
// response channel: valid/ready handshake with key, flags and status
// depends on dlle_pkg
interface dlle_rsp_if
    import dlle_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [KEY_W-1:0]  out_key;
    logic                     element_valid;
    logic                     last;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output out_key, output element_valid, output last,
                    output status, input ready);
    modport sink   (input valid, input out_key, input element_valid, input last,
                    input status, output ready);
endinterface

FILE: design/dlle_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dlle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: design/doubly_linked_list_engine.sv
// Bounded doubly linked list of signed keys with a sentinel. Keys and next/prev
// links live in three rams with registered read data; the sentinel's links are the
// head and tail registers. Freed slots go on a stack ram, and slots never used
// are handed out by a counter, so no clearing pass follows reset. One command
// is worked at a time. Insert passes through decode, alloc (only when a freed
// slot is reused), link and fix (only when the list was not empty); delete
// first/last passes through decode and unlink, and delete key and dump walk
// from the head along the next links; a stall on the response channel holds
// the engine. Each command ends in one or more response beats, the final one
// with last set.
// depends on dlle_pkg, dlle_cmd_if, dlle_rsp_if, dlle_ram and the macro header
`include "doubly_linked_list_engine_macros.svh"

module doubly_linked_list_engine
    import dlle_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dlle_cmd_if.sink     i_cmd,
    dlle_rsp_if.source   o_rsp
);
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] SENT = LW'(CAPACITY);

    t_state                   r_state, n_state;
    logic [ACTION_W-1:0]      r_act;
    logic signed [KEY_W-1:0]  r_key;
    logic [LW-1:0]            r_head, n_head;
    logic [LW-1:0]            r_tail, n_tail;
    logic [LW-1:0]            r_rec, n_rec;
    logic [LW-1:0]            r_fresh, n_fresh;
    logic [LW-1:0]            r_cur, n_cur;
    logic [LW-1:0]            r_aux, n_aux;
    logic [IW-1:0]            r_slot, n_slot;
    t_status                  r_status, n_status;

    logic                     r_ov;
    logic signed [KEY_W-1:0]  r_o_key;
    logic                     r_o_elem;
    logic                     r_o_last;
    t_status                  r_o_status;

    logic                     cmd_acc;
    logic                     can_emit;
    logic                     emit;
    logic signed [KEY_W-1:0]  e_key;
    logic                     e_elem;
    logic                     e_last;
    t_status                  e_status;
    logic                     unlink;
    logic                     is_full;
    logic                     key_hit;
    logic [LW-1:0]            rec_m1;

    logic                     key_we;
    logic                     nx_we;
    logic [IW-1:0]            nx_wa;
    logic [LW-1:0]            nx_wd;
    logic                     pv_we;
    logic [IW-1:0]            pv_wa;
    logic [LW-1:0]            pv_wd;
    logic                     st_we;
    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic                     st_rd_en;
    logic [KEY_W-1:0]         key_rd;
    logic [LW-1:0]            nx_rd;
    logic [LW-1:0]            pv_rd;
    logic [IW-1:0]            st_rd;

    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign can_emit    = !r_ov || o_rsp.ready;
    assign is_full     = (r_rec == '0) && (r_fresh == SENT);
    assign key_hit     = ($signed(key_rd) == r_key);
    assign rec_m1      = r_rec - 1'b1;

    dlle_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_keys (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (r_slot),
        .i_wr_data (r_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (key_rd)
    );

    dlle_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
        .i_clk     (i_clk),
        .i_wr_en   (nx_we),
        .i_wr_addr (nx_wa),
        .i_wr_data (nx_wd),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (nx_rd)
    );

    dlle_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev (
        .i_clk     (i_clk),
        .i_wr_en   (pv_we),
        .i_wr_addr (pv_wa),
        .i_wr_data (pv_wd),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (pv_rd)
    );

    dlle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free (
        .i_clk     (i_clk),
        .i_wr_en   (st_we),
        .i_wr_addr (r_rec[IW-1:0]),
        .i_wr_data (r_cur[IW-1:0]),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (rec_m1[IW-1:0]),
        .o_rd_data (st_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_acc) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (r_act) inside
                    ACT_INSERT: begin
                        if (is_full) begin
                            n_state = ST_RESP;
                        end else if (r_rec != '0) begin
                            n_state = ST_ALLOC;
                        end else begin
                            n_state = ST_LINK;
                        end
                    end
                    ACT_DEL_KEY, ACT_DUMP: begin
                        n_state = (r_head == SENT) ? ST_RESP : ST_WALK;
                    end
                    ACT_DEL_FIRST: begin
                        n_state = (r_head == SENT) ? ST_RESP : ST_UNLINK;
                    end
                    ACT_DEL_LAST: begin
                        n_state = (r_tail == SENT) ? ST_RESP : ST_UNLINK;
                    end
                    default: begin
                        n_state = ST_RESP;
                    end
                endcase
            end
            ST_ALLOC: begin
                n_state = ST_LINK;
            end
            ST_LINK: begin
                n_state = (r_head != SENT) ? ST_FIX : ST_RESP;
            end
            ST_FIX: begin
                n_state = ST_RESP;
            end
            ST_WALK: begin
                if (r_act == ACT_DUMP) begin
                    if (can_emit && nx_rd == SENT) begin
                        n_state = ST_IDLE;
                    end
                end else if (key_hit || nx_rd == SENT) begin
                    n_state = ST_RESP;
                end
            end
            ST_UNLINK: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (can_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_rec    = r_rec;
        n_fresh  = r_fresh;
        n_cur    = r_cur;
        n_aux    = r_aux;
        n_slot   = r_slot;
        n_status = r_status;
        key_we   = 1'b0;
        nx_we    = 1'b0;
        nx_wa    = r_slot;
        nx_wd    = r_head;
        pv_we    = 1'b0;
        pv_wa    = r_slot;
        pv_wd    = SENT;
        st_we    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_cur[IW-1:0];
        st_rd_en = 1'b0;
        emit     = 1'b0;
        e_key    = '0;
        e_elem   = 1'b0;
        e_last   = 1'b1;
        e_status = r_status;
        unlink   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_DECODE: begin
                case (r_act) inside
                    ACT_INSERT: begin
                        if (is_full) begin
                            n_status = STS_FULL;
                        end else if (r_rec != '0) begin
                            st_rd_en = 1'b1;
                            n_rec    = rec_m1;
                        end else begin
                            n_slot  = r_fresh[IW-1:0];
                            n_fresh = r_fresh + 1'b1;
                        end
                    end
                    ACT_DEL_KEY, ACT_DUMP: begin
                        n_status = (r_act == ACT_DUMP) ? STS_OK : STS_NOT_FOUND;
                        if (r_head != SENT) begin
                            rd_en   = 1'b1;
                            rd_addr = r_head[IW-1:0];
                            n_cur   = r_head;
                        end
                    end
                    ACT_DEL_FIRST: begin
                        n_status = STS_NOT_FOUND;
                        if (r_head != SENT) begin
                            rd_en   = 1'b1;
                            rd_addr = r_head[IW-1:0];
                            n_cur   = r_head;
                        end
                    end
                    ACT_DEL_LAST: begin
                        n_status = STS_NOT_FOUND;
                        if (r_tail != SENT) begin
                            rd_en   = 1'b1;
                            rd_addr = r_tail[IW-1:0];
                            n_cur   = r_tail;
                        end
                    end
                    default: begin
                        n_status = STS_OK;
                    end
                endcase
            end
            ST_ALLOC: begin
                n_slot = st_rd;
            end
            ST_LINK: begin
                key_we   = 1'b1;
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                n_head   = LW'(r_slot);
                n_aux    = r_head;
                n_status = STS_OK;
                if (r_head == SENT) begin
                    n_tail = LW'(r_slot);
                end
            end
            ST_FIX: begin
                pv_we = 1'b1;
                pv_wa = r_aux[IW-1:0];
                pv_wd = LW'(r_slot);
            end
            ST_WALK: begin
                if (r_act == ACT_DUMP) begin
                    if (can_emit) begin
                        emit     = 1'b1;
                        e_key    = $signed(key_rd);
                        e_elem   = 1'b1;
                        e_last   = (nx_rd == SENT);
                        e_status = STS_OK;
                        if (nx_rd != SENT) begin
                            rd_en   = 1'b1;
                            rd_addr = nx_rd[IW-1:0];
                            n_cur   = nx_rd;
                        end
                    end
                end else if (key_hit) begin
                    unlink   = 1'b1;
                    n_status = STS_OK;
                end else if (nx_rd != SENT) begin
                    rd_en   = 1'b1;
                    rd_addr = nx_rd[IW-1:0];
                    n_cur   = nx_rd;
                end
            end
            ST_UNLINK: begin
                unlink   = 1'b1;
                n_status = STS_OK;
            end
            ST_RESP: begin
                emit = can_emit;
            end
            default: begin
            end
        endcase

        if (unlink) begin
            st_we = 1'b1;
            n_rec = r_rec + 1'b1;
            if (pv_rd == SENT) begin
                n_head = nx_rd;
            end else begin
                nx_we = 1'b1;
                nx_wa = pv_rd[IW-1:0];
                nx_wd = nx_rd;
            end
            if (nx_rd == SENT) begin
                n_tail = pv_rd;
            end else begin
                pv_we = 1'b1;
                pv_wa = nx_rd[IW-1:0];
                pv_wd = pv_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= SENT;
            r_tail   <= SENT;
            r_rec    <= '0;
            r_fresh  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_rec    <= n_rec;
            r_fresh  <= n_fresh;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_act <= i_cmd.action;
            r_key <= i_cmd.key;
        end
        r_cur    <= n_cur;
        r_aux    <= n_aux;
        r_slot   <= n_slot;
        r_status <= n_status;
        if (emit) begin
            r_o_key    <= e_key;
            r_o_elem   <= e_elem;
            r_o_last   <= e_last;
            r_o_status <= e_status;
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.out_key       = r_o_key;
    assign o_rsp.element_valid = r_o_elem;
    assign o_rsp.last          = r_o_last;
    assign o_rsp.status        = r_o_status;

    `DLLE_ASSERT_IMPLY(a_rec_bound, i_clk, i_rst_n, 1'b1, r_rec <= r_fresh, "more freed slots than allocated")
    `DLLE_ASSERT_IMPLY(a_ends_agree, i_clk, i_rst_n, 1'b1, (r_head == SENT) == (r_tail == SENT), "head and tail disagree on empty")
    `DLLE_ASSERT_IMPLY(a_empty_count, i_clk, i_rst_n, r_state == ST_IDLE, (r_head == SENT) == (r_fresh == r_rec), "list emptiness and slot count disagree")
    `DLLE_ASSERT_NEXT(a_acc_decode, i_clk, i_rst_n, cmd_acc, r_state == ST_DECODE, "accepted command not decoded")
endmodule
